// ===== rtl/core/fcdk_pkg.sv =====
`timescale 1ns / 1ps

package fcdk_pkg;

	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] REG_NEAR_CLIP_ENABLE  = 3'd0;
	localparam logic [2:0] REG_CLIP_MARKER       = 3'd1;
	localparam logic [2:0] REG_DEPTH_OFFSET      = 3'd2;
	localparam logic [2:0] REG_DEPTH_LEVEL_COUNT = 3'd3;
	localparam logic [2:0] REG_STASH_ENABLE      = 3'd4;
	localparam logic [2:0] REG_WINDING_FLIP      = 3'd5;

	localparam logic [31:0] CLIP_MARKER_RST = 32'hFFFF_EC78;
	localparam logic [16:0] LEVEL_COUNT_RST = 17'd4096;
	localparam logic [31:0] DEPTH_SCALE     = 32'd21845;
	localparam logic [15:0] KEY_BASE        = 16'hFFFF;

	localparam logic [2:0] ORD_ABC = 3'd0;
	localparam logic [2:0] ORD_ACB = 3'd1;
	localparam logic [2:0] ORD_BCA = 3'd2;
	localparam logic [2:0] ORD_BAC = 3'd3;
	localparam logic [2:0] ORD_CAB = 3'd4;
	localparam logic [2:0] ORD_CBA = 3'd5;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
		logic [14:0]        face_index;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        sort_key;
		logic               accepted;
		logic signed [31:0] x_first;
		logic signed [31:0] x_second;
		logic signed [31:0] x_third;
		logic signed [31:0] y_first;
		logic signed [31:0] y_second;
		logic signed [31:0] y_third;
		logic               clip_flag;
		logic [2:0]         order_code;
	} out_item_t;

	typedef struct packed {
		logic neg;
		logic zero;
	} wind_t;

endpackage

// ===== rtl/core/face_cull_depth_key_core.sv =====
`timescale 1ns / 1ps
// channel   handshake                      payload
// item      start, busy (transfer when     item   (fcdk_pkg::in_item_t)
//           start && !busy)
// result    done (one-cycle strobe)        result (fcdk_pkg::out_item_t)
// config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One item per cycle; each result passes the stage 1, stage 2 and stage 3 registers
// and is shown with done.
// The stage chain is deltas -> 32x32 products -> 64-bit winding
// subtract and depth add/compare. busy is held low: there is no stall.
// arst_n clears the valid bits and restores the register reset values.

module face_cull_depth_key_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  fcdk_pkg::in_item_t            item,
	output logic                          done,
	output fcdk_pkg::out_item_t           result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fcdk_pkg::ADDR_W-1:0]   paddr,
	input  logic [fcdk_pkg::DATA_W-1:0]   pwdata,
	output logic [fcdk_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	logic        near_clip_q;
	logic [31:0] clip_marker_q;
	logic [31:0] depth_offset_q;
	logic [16:0] level_count_q;
	logic        stash_q;
	logic        flip_q;

	logic        wr_en;
	logic [2:0]  reg_idx;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_clip_q    <= 1'b0;
			clip_marker_q  <= fcdk_pkg::CLIP_MARKER_RST;
			depth_offset_q <= 32'd0;
			level_count_q  <= fcdk_pkg::LEVEL_COUNT_RST;
			stash_q        <= 1'b1;
			flip_q         <= 1'b0;
		end else if (wr_en) begin
			case (reg_idx)
				fcdk_pkg::REG_NEAR_CLIP_ENABLE:  near_clip_q    <= pwdata[0];
				fcdk_pkg::REG_CLIP_MARKER:       clip_marker_q  <= pwdata;
				fcdk_pkg::REG_DEPTH_OFFSET:      depth_offset_q <= pwdata;
				fcdk_pkg::REG_DEPTH_LEVEL_COUNT: level_count_q  <= pwdata[16:0];
				fcdk_pkg::REG_STASH_ENABLE:      stash_q        <= pwdata[0];
				fcdk_pkg::REG_WINDING_FLIP:      flip_q         <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			fcdk_pkg::REG_NEAR_CLIP_ENABLE:  prdata = {31'd0, near_clip_q};
			fcdk_pkg::REG_CLIP_MARKER:       prdata = clip_marker_q;
			fcdk_pkg::REG_DEPTH_OFFSET:      prdata = depth_offset_q;
			fcdk_pkg::REG_DEPTH_LEVEL_COUNT: prdata = {15'd0, level_count_q};
			fcdk_pkg::REG_STASH_ENABLE:      prdata = {31'd0, stash_q};
			fcdk_pkg::REG_WINDING_FLIP:      prdata = {31'd0, flip_q};
			default:                         prdata = '0;
		endcase
	end

	// stage 1: depth sum, clip match, y order
	logic        take;
	logic        le_ab, le_ac, le_bc, le_ca;
	logic [2:0]  ord;
	logic        clip;

	logic        vld_s1, vld_s2, vld_s3;
	logic [31:0] zsum_s1;
	logic        clip_s1;
	logic [2:0]  ord_s1;
	logic [14:0] face_s1;
	logic [31:0] ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;

	assign take  = start && !busy;
	assign le_ab = item.a_y <= item.b_y;
	assign le_ac = item.a_y <= item.c_y;
	assign le_bc = item.b_y <= item.c_y;
	assign le_ca = item.c_y <= item.a_y;
	assign clip  = near_clip_q && ((item.a_x == clip_marker_q) ||
		(item.b_x == clip_marker_q) || (item.c_x == clip_marker_q));

	always_comb begin
		if (le_ab && le_ac)
			ord = le_bc ? fcdk_pkg::ORD_ABC : fcdk_pkg::ORD_ACB;
		else if (le_bc)
			ord = le_ca ? fcdk_pkg::ORD_BCA : fcdk_pkg::ORD_BAC;
		else
			ord = le_ab ? fcdk_pkg::ORD_CAB : fcdk_pkg::ORD_CBA;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		zsum_s1 <= item.a_z + item.b_z + item.c_z;
		clip_s1 <= clip;
		ord_s1  <= ord;
		face_s1 <= item.face_index;
		ax_s1   <= item.a_x;
		ay_s1   <= item.a_y;
		bx_s1   <= item.b_x;
		by_s1   <= item.b_y;
		cx_s1   <= item.c_x;
		cy_s1   <= item.c_y;
	end

	// stage 2: depth scale, vertex permutation
	logic [31:0] m_s2;
	logic        clip_s2;
	logic [2:0]  ord_s2;
	logic [14:0] face_s2;
	logic [31:0] x0_s2, x1_s2, x2_s2, y0_s2, y1_s2, y2_s2;
	logic [31:0] x0, x1, x2, y0, y1, y2;

	always_comb begin
		case (ord_s1)
			fcdk_pkg::ORD_ABC: begin
				x0 = ax_s1; x1 = bx_s1; x2 = cx_s1; y0 = ay_s1; y1 = by_s1; y2 = cy_s1;
			end
			fcdk_pkg::ORD_ACB: begin
				x0 = ax_s1; x1 = cx_s1; x2 = bx_s1; y0 = ay_s1; y1 = cy_s1; y2 = by_s1;
			end
			fcdk_pkg::ORD_BCA: begin
				x0 = bx_s1; x1 = cx_s1; x2 = ax_s1; y0 = by_s1; y1 = cy_s1; y2 = ay_s1;
			end
			fcdk_pkg::ORD_BAC: begin
				x0 = bx_s1; x1 = ax_s1; x2 = cx_s1; y0 = by_s1; y1 = ay_s1; y2 = cy_s1;
			end
			fcdk_pkg::ORD_CAB: begin
				x0 = cx_s1; x1 = ax_s1; x2 = bx_s1; y0 = cy_s1; y1 = ay_s1; y2 = by_s1;
			end
			default: begin
				x0 = cx_s1; x1 = bx_s1; x2 = ax_s1; y0 = cy_s1; y1 = by_s1; y2 = ay_s1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		m_s2    <= 32'(zsum_s1 * fcdk_pkg::DEPTH_SCALE);
		clip_s2 <= clip_s1;
		ord_s2  <= stash_q ? ord_s1 : fcdk_pkg::ORD_ABC;
		face_s2 <= face_s1;
		x0_s2   <= stash_q ? x0 : 32'd0;
		x1_s2   <= stash_q ? x1 : 32'd0;
		x2_s2   <= stash_q ? x2 : 32'd0;
		y0_s2   <= stash_q ? y0 : 32'd0;
		y1_s2   <= stash_q ? y1 : 32'd0;
		y2_s2   <= stash_q ? y2 : 32'd0;
	end

	// stage 3: winding sign, depth offset, acceptance and key
	fcdk_pkg::wind_t wind;
	logic [31:0]     depth;
	logic            front;
	logic            level_ok;

	fcdk_winding u_winding (
		.clk  (clk),
		.item (item),
		.wind (wind)
	);

	assign depth    = {{16{m_s2[31]}}, m_s2[31:16]} + depth_offset_q;
	assign level_ok = depth < {15'd0, level_count_q};
	assign front    = flip_q ? wind.neg : (!wind.neg && !wind.zero);

	always_ff @(posedge clk) begin
		result.sort_key   <= {fcdk_pkg::KEY_BASE - depth[15:0], 1'b0, face_s2};
		result.clip_flag  <= clip_s2;
		result.order_code <= ord_s2;
		result.x_first    <= x0_s2;
		result.x_second   <= x1_s2;
		result.x_third    <= x2_s2;
		result.y_first    <= y0_s2;
		result.y_second   <= y1_s2;
		result.y_third    <= y2_s2;
		result.accepted   <= level_ok && (front || clip_s2);
	end

	assign done = vld_s3;

	a_done_follows_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(take, 3))
		else $error("result without a matching transfer");

	a_order_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.order_code != 3'd6) && (result.order_code != 3'd7))
		else $error("order code out of range");

	a_stash_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !stash_q |-> (result.order_code == 3'd0) && (result.y_first == 32'd0))
		else $error("stash off but vertex fields not cleared");

	a_clip_needs_enable: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.clip_flag |-> near_clip_q)
		else $error("clip flag with near clipping off");

	a_winding_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> !(wind.neg && wind.zero))
		else $error("winding sign and zero both set");

endmodule

// ===== rtl/core/fcdk_winding.sv =====
`timescale 1ns / 1ps

module fcdk_winding (
	input  logic               clk,
	input  fcdk_pkg::in_item_t item,
	output fcdk_pkg::wind_t    wind
);

	logic signed [31:0] dx1_s1, dy1_s1, dx2_s1, dy2_s1;
	logic signed [63:0] p1_s2, p2_s2;
	logic signed [63:0] w;

	always_ff @(posedge clk) begin
		dx1_s1 <= item.a_x - item.b_x;
		dy1_s1 <= item.a_y - item.b_y;
		dx2_s1 <= item.c_x - item.b_x;
		dy2_s1 <= item.c_y - item.b_y;
	end

	always_ff @(posedge clk) begin
		p1_s2 <= 64'(dx1_s1) * 64'(dy2_s1);
		p2_s2 <= 64'(dy1_s1) * 64'(dx2_s1);
	end

	assign w = p1_s2 - p2_s2;

	assign wind.neg  = w[63];
	assign wind.zero = (w == 64'sd0);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import fcdk_pkg::*;

	localparam logic [2:0]  REG_UNUSED   = 3'd6;
	localparam logic [31:0] Z_SCALE      = 32'd21845;
	localparam logic [31:0] Z_SUM_INV    = 32'hFFFC_FFFD;
	localparam int unsigned TOTAL_FACES  = 1850;
	localparam int unsigned DRAIN_CYCLES = 6;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	in_item_t            item;
	logic                done;
	out_item_t           result;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	logic                cfg_near_clip;
	logic [31:0]         cfg_marker;
	logic [31:0]         cfg_offset;
	logic [16:0]         cfg_levels;
	logic                cfg_stash;
	logic                cfg_flip;

	out_item_t           pending_faces[$];
	int unsigned         error_count;
	int unsigned         faces_sent;
	int unsigned         burst_left;
	bit                  gaps_on;

	face_cull_depth_key_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.item    (item),
		.done    (done),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic out_item_t cull_and_key(input in_item_t f);
		out_item_t          r;
		logic [31:0]        xs [3];
		logic [31:0]        ys [3];
		logic [31:0]        dx1, dy1, dx2, dy2;
		logic [31:0]        zsum, zscaled, depth;
		logic signed [63:0] winding;
		logic               front, clip;
		logic [2:0]         code;
		int                 order [3];
		r = '0;
		xs = '{f.a_x, f.b_x, f.c_x};
		ys = '{f.a_y, f.b_y, f.c_y};
		dx1 = f.a_x - f.b_x;
		dy1 = f.a_y - f.b_y;
		dx2 = f.c_x - f.b_x;
		dy2 = f.c_y - f.b_y;
		winding = longint'($signed(dx1)) * longint'($signed(dy2))
			- longint'($signed(dy1)) * longint'($signed(dx2));
		front = cfg_flip ? winding[63] : (!winding[63] && winding != 64'sd0);
		clip = cfg_near_clip && (xs[0] == cfg_marker || xs[1] == cfg_marker
			|| xs[2] == cfg_marker);
		zsum = f.a_z + f.b_z + f.c_z;
		zscaled = zsum * Z_SCALE;
		depth = {{16{zscaled[31]}}, zscaled[31:16]} + cfg_offset;
		r.accepted = (front || clip) && (depth < {15'b0, cfg_levels});
		r.sort_key = ((32'h0000_FFFF - depth) << 16) | {17'b0, f.face_index};
		r.clip_flag = clip;
		if (cfg_stash) begin
			if (f.a_y <= f.b_y && f.a_y <= f.c_y)
				code = (f.b_y <= f.c_y) ? ORD_ABC : ORD_ACB;
			else if (f.b_y <= f.c_y)
				code = (f.c_y <= f.a_y) ? ORD_BCA : ORD_BAC;
			else
				code = (f.a_y <= f.b_y) ? ORD_CAB : ORD_CBA;
			case (code)
				ORD_ABC: order = '{0, 1, 2};
				ORD_ACB: order = '{0, 2, 1};
				ORD_BCA: order = '{1, 2, 0};
				ORD_BAC: order = '{1, 0, 2};
				ORD_CAB: order = '{2, 0, 1};
				default: order = '{2, 1, 0};
			endcase
			r.x_first = xs[order[0]];
			r.x_second = xs[order[1]];
			r.x_third = xs[order[2]];
			r.y_first = ys[order[0]];
			r.y_second = ys[order[1]];
			r.y_third = ys[order[2]];
			r.order_code = code;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0t ns mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pending_faces.size() == 0) begin
				report_mismatch("result with no face pending");
			end else begin
				want = pending_faces.pop_front();
				check_field("sort_key", result.sort_key, want.sort_key);
				check_field("accepted", result.accepted, want.accepted);
				check_field("x_first", result.x_first, want.x_first);
				check_field("x_second", result.x_second, want.x_second);
				check_field("x_third", result.x_third, want.x_third);
				check_field("y_first", result.y_first, want.y_first);
				check_field("y_second", result.y_second, want.y_second);
				check_field("y_third", result.y_third, want.y_third);
				check_field("clip_flag", result.clip_flag, want.clip_flag);
				check_field("order_code", result.order_code, want.order_code);
			end
		end
	end

	task automatic send_face(input in_item_t face);
		start <= 1'b1;
		item <= face;
		do @(posedge clk); while (busy !== 1'b0);
		pending_faces.push_back(cull_and_key(face));
		faces_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		while (pending_faces.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_NEAR_CLIP_ENABLE:  cfg_near_clip = value[0];
			REG_CLIP_MARKER:       cfg_marker = value;
			REG_DEPTH_OFFSET:      cfg_offset = value;
			REG_DEPTH_LEVEL_COUNT: cfg_levels = value[16:0];
			REG_STASH_ENABLE:      cfg_stash = value[0];
			REG_WINDING_FLIP:      cfg_flip = value[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic in_item_t make_face(input logic [31:0] ax, ay, az, bx, by, bz,
			cx, cy, cz, input logic [14:0] face);
		in_item_t f;
		f.a_x = ax;
		f.a_y = ay;
		f.a_z = az;
		f.b_x = bx;
		f.b_y = by;
		f.b_z = bz;
		f.c_x = cx;
		f.c_y = cy;
		f.c_z = cz;
		f.face_index = face;
		return f;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4, 5: return 32'($urandom_range(0, 4000)) - 32'd2000;
			default: return $urandom();
		endcase
	endfunction

	function automatic in_item_t random_face();
		in_item_t    f;
		logic [31:0] tgt;
		logic [31:0] m;
		f.a_x = rand_coord();
		f.a_y = rand_coord();
		f.a_z = rand_coord();
		f.b_x = rand_coord();
		f.b_y = rand_coord();
		f.b_z = rand_coord();
		f.c_x = rand_coord();
		f.c_y = rand_coord();
		f.c_z = rand_coord();
		case ($urandom_range(0, 11))
			0: f.b_y = f.a_y;
			1: f.c_y = f.b_y;
			2: f.c_y = f.a_y;
			3: begin
				f.b_y = f.a_y;
				f.c_y = f.a_y;
			end
			4: begin
				f.c_x = f.b_x;
				f.c_y = f.b_y;
			end
			default: ;
		endcase
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 2))
				0: f.a_x = cfg_marker;
				1: f.b_x = cfg_marker;
				default: f.c_x = cfg_marker;
			endcase
		end
		if ($urandom_range(0, 2) != 0) begin
			tgt = $urandom_range(0, 32'(cfg_levels) + 2) - cfg_offset;
			m = {tgt[15:0], 16'($urandom())};
			f.c_z = m * Z_SUM_INV - f.a_z - f.b_z;
		end
		case ($urandom_range(0, 7))
			0: f.face_index = 15'h7FFF;
			1: f.face_index = 15'h0000;
			default: f.face_index = 15'($urandom());
		endcase
		return f;
	endfunction

	task automatic randomise_setup();
		logic [31:0] offs;
		logic [31:0] levels;
		case ($urandom_range(0, 5))
			0: offs = 32'h7FFF_FFFF;
			1: offs = 32'h8000_0000;
			2: offs = 32'h0;
			3: offs = $urandom();
			default: offs = 32'($urandom_range(0, 40000)) - 32'd20000;
		endcase
		case ($urandom_range(0, 5))
			0: levels = 32'd0;
			1: levels = 32'd65536;
			2: levels = 32'd1;
			default: levels = $urandom_range(0, 65536);
		endcase
		write_reg(REG_NEAR_CLIP_ENABLE, $urandom_range(0, 1));
		write_reg(REG_CLIP_MARKER, rand_coord());
		write_reg(REG_DEPTH_OFFSET, offs);
		write_reg(REG_DEPTH_LEVEL_COUNT, levels);
		write_reg(REG_STASH_ENABLE, ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0);
		write_reg(REG_WINDING_FLIP, $urandom_range(0, 1));
		gaps_on = ($urandom_range(0, 3) != 0);
	endtask

	task automatic test_reset_defaults();
		send_face(make_face(0, 1, 10, 50, 2, 20, 10, 3, 0, 15'd1));
		send_face(make_face(0, 1, 10, 0, 3, 10, 10, 2, 10, 15'd2));
		send_face(make_face(0, 3, 10, 10, 1, 10, 0, 2, 10, 15'd3));
		send_face(make_face(0, 2, 10, 0, 1, 10, 10, 3, 10, 15'd4));
		send_face(make_face(-7, 2, 0, 5, 3, 0, 9, 1, 0, 15'd5));
		send_face(make_face(4, 3, 1, -4, 2, 1, 8, 1, 1, 15'd6));
		send_face(make_face(0, 5, 0, 0, 5, 0, 0, 5, 0, 15'd7));
		send_face(make_face(3, 1, 2, 6, 1, 2, 9, 0, 2, 15'd8));
		send_face(make_face(0, 0, -3, 0, 10, -3, 10, 0, -3, 15'd9));
		send_face(make_face(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 15'h7FFF));
		send_face(make_face(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 15'h0000));
		send_face(make_face(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 15'h2AAA));
		send_face(make_face(-5000, 0, 1, 10, 0, 1, 0, 10, 1, 15'h5555));
		settle();
	endtask

	task automatic test_near_clip();
		write_reg(REG_NEAR_CLIP_ENABLE, 32'd1);
		send_face(make_face(-5000, 0, 1, 10, 0, 1, 0, 10, 1, 15'd20));
		settle();
		write_reg(REG_CLIP_MARKER, 32'h7FFF_FFFF);
		send_face(make_face(0, 0, 1, 32'h7FFF_FFFF, 0, 1, 0, 10, 1, 15'd21));
		settle();
		write_reg(REG_CLIP_MARKER, 32'h8000_0000);
		send_face(make_face(0, 0, 1, 10, 0, 1, 32'h8000_0000, 10, 1, 15'd22));
		send_face(make_face(0, 0, 1, 10, 0, 1, 0, 10, 1, 15'd23));
		settle();
		write_reg(REG_NEAR_CLIP_ENABLE, 32'd0);
	endtask

	task automatic test_depth_range();
		write_reg(REG_DEPTH_LEVEL_COUNT, 32'd0);
		send_face(make_face(0, 0, 0, 0, 10, 0, 10, 0, 0, 15'd30));
		settle();
		write_reg(REG_DEPTH_LEVEL_COUNT, 32'd65536);
		write_reg(REG_DEPTH_OFFSET, 32'd65535);
		send_face(make_face(0, 0, 0, 0, 10, 0, 10, 0, 0, 15'd31));
		settle();
		write_reg(REG_DEPTH_OFFSET, 32'd65536);
		send_face(make_face(0, 0, 0, 0, 10, 0, 10, 0, 0, 15'd32));
		settle();
		write_reg(REG_DEPTH_OFFSET, 32'h8000_0000);
		send_face(make_face(0, 0, 32'h7FFF_FFFF, 0, 10, 32'h7FFF_FFFF,
			10, 0, 32'h7FFF_FFFF, 15'd33));
		settle();
		write_reg(REG_DEPTH_OFFSET, 32'h7FFF_FFFF);
		write_reg(REG_UNUSED, 32'h0);
		send_face(make_face(0, 0, 32'h8000_0000, 0, 10, 32'h8000_0000,
			10, 0, 1, 15'd34));
		settle();
		write_reg(REG_DEPTH_OFFSET, 32'd0);
		write_reg(REG_DEPTH_LEVEL_COUNT, 32'd4096);
	endtask

	task automatic test_stash_and_flip();
		write_reg(REG_STASH_ENABLE, 32'd0);
		send_face(make_face(7, 9, 3, 0, 2, 3, 5, 4, 3, 15'd40));
		settle();
		write_reg(REG_WINDING_FLIP, 32'd1);
		send_face(make_face(0, 0, 3, 10, 0, 3, 0, 10, 3, 15'd41));
		send_face(make_face(0, 0, 3, 10, 10, 3, 10, 10, 3, 15'd42));
		send_face(make_face(0, 0, 3, 0, 10, 3, 10, 0, 3, 15'd43));
		settle();
		write_reg(REG_STASH_ENABLE, 32'd1);
		write_reg(REG_WINDING_FLIP, 32'd0);
	endtask

	task automatic test_random();
		int unsigned phase_items;
		while (faces_sent < TOTAL_FACES) begin
			settle();
			randomise_setup();
			phase_items = $urandom_range(120, 260);
			repeat (phase_items)
				if (faces_sent < TOTAL_FACES)
					send_face(random_face());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		item <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cfg_near_clip = 1'b0;
		cfg_marker = 32'hFFFF_EC78;
		cfg_offset = 32'h0;
		cfg_levels = 17'd4096;
		cfg_stash = 1'b1;
		cfg_flip = 1'b0;
		error_count = 0;
		faces_sent = 0;
		burst_left = $urandom_range(1, 24);
		gaps_on = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_near_clip();
		test_depth_range();
		test_stash_and_flip();
		test_random();
		settle();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
